FILE: rtl/mcjb_pkg.sv
// Shared types, codes and constants of the Clause-45 MDIO frame builder.
package mcjb_pkg;

  // Field widths of the item channels
  localparam int unsigned OP_W   = 3;
  localparam int unsigned PHY_W  = 5;
  localparam int unsigned DEV_W  = 5;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FRAME_WORD_W = 32;

  // Preamble length counter and frame length widths
  localparam int unsigned PRE_W  = 4;
  localparam int unsigned FLEN_W = 5;

  // Defaults handed to the top level parameters
  localparam int unsigned PREAMBLE_BYTES_DEF = 4;
  localparam int unsigned QUEUE_DEPTH_DEF    = 2;

  // Frame constants
  localparam logic [DEV_W-1:0]  JTAG_DEV       = 5'h1f;
  localparam logic [WORD_W-1:0] PIN_SHADOW_REG = 16'h0010;
  localparam logic [3:0]        WR_CODE        = 4'h1;
  localparam logic [3:0]        RD_CODE        = 4'h3;
  localparam logic [3:0]        ADDR_CODE      = 4'h0;
  localparam logic [1:0]        TA_BITS        = 2'b10;
  localparam logic [WORD_W-1:0] READ_FILL      = 16'hffff;
  localparam logic [BYTE_W-1:0] PRE_BYTE       = 8'hff;
  localparam logic [PHY_W-1:0]  MGMT_PHY_RST   = 5'h1a;

  // Configuration register map
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_MGMT_PHY = 2'd0,
    REG_TARGET   = 2'd1,
    REG_FAST_PRE = 2'd2
  } reg_idx_e;

  // Input item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_MDIO_WR    = 3'd0,
    OP_MDIO_RD    = 3'd1,
    OP_JTAG_PINS  = 3'd2,
    OP_JTAG_RST   = 3'd3,
    OP_TDO_SAMPLE = 3'd4,
    OP_RX_BYTE    = 3'd5
  } op_e;

  // Serializer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE0,
    ST_WORD0,
    ST_PRE1,
    ST_WORD1
  } back_state_e;

  // Configuration seen by the front end
  typedef struct packed {
    logic [PHY_W-1:0] mgmt_phy;
    logic             target_sel;
    logic             fast_pre;
  } cfg_t;

  // Job handed from the front end to the serializer
  typedef struct packed {
    logic                    is_done;
    logic [PRE_W-1:0]        pre_len;
    logic [FRAME_WORD_W-1:0] addr_word;
    logic [FRAME_WORD_W-1:0] value_word;
    logic [WORD_W-1:0]       read_value;
    logic                    tdo;
  } job_t;

endpackage

FILE: rtl/mcjb_in_if.sv
// Input item channel: op codes, frame operands and received bytes.
interface mcjb_in_if;
  import mcjb_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [PHY_W-1:0]  phy_field;
  logic [DEV_W-1:0]  device_type;
  logic [WORD_W-1:0] reg_addr;
  logic [WORD_W-1:0] write_data;
  logic              tck;
  logic              tms;
  logic              tdi;
  logic              trst;
  logic [BYTE_W-1:0] rx_byte;

  modport source (
    output valid, op, phy_field, device_type, reg_addr, write_data,
           tck, tms, tdi, trst, rx_byte,
    input  ready
  );

  modport sink (
    input  valid, op, phy_field, device_type, reg_addr, write_data,
           tck, tms, tdi, trst, rx_byte,
    output ready
  );
endinterface

FILE: rtl/mcjb_out_if.sv
// Result item channel: frame bytes and read completions.
interface mcjb_out_if;
  import mcjb_pkg::*;

  logic              valid;
  logic              ready;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic              tx_last;
  logic              done_res;
  logic [WORD_W-1:0] read_value;
  logic              tdo;

  modport source (
    output valid, tx_valid, tx_byte, tx_last, done_res, read_value, tdo,
    input  ready
  );

  modport sink (
    input  valid, tx_valid, tx_byte, tx_last, done_res, read_value, tdo,
    output ready
  );
endinterface

FILE: rtl/mdio_c45_jtag_bridge_framer.sv
// Top level of the Clause-45 MDIO frame builder with its register port.
// Each mdio write, mdio read, jtag pins, jtag reset or tdo sample item yields one frame of
// 2*(P+4) bytes, P being PREAMBLE_BYTES or 1 in fast mode (16 bytes at the default), sent
// one byte per cycle while the result side is ready. The serializer has a single byte path
// and takes the next job only once a frame's last byte is out. Received-byte items are
// taken one per cycle while the job queue (QUEUE_DEPTH entries) has room; the frame's last
// received byte yields one completion result carrying the last two bytes and the tdo bit of
// the selected target. Configuration registers sit at byte addresses 0 (management PHY
// address), 4 (target_select) and 8 (fast_preamble).
module mdio_c45_jtag_bridge_framer #(
  parameter int unsigned PREAMBLE_BYTES = mcjb_pkg::PREAMBLE_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH    = mcjb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mcjb_in_if.sink                       in_i,
  mcjb_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcjb_pkg::PADDR_W-1:0]  paddr,
  input  logic [mcjb_pkg::PDATA_W-1:0]  pwdata,
  output logic [mcjb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import mcjb_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  logic     push;
  job_t     push_job;
  logic     full;
  logic     pop;
  logic     job_valid;
  job_t     pop_job;

  // Decode register writes
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_MGMT_PHY: cfg_d.mgmt_phy   = pwdata[PHY_W-1:0];
        REG_TARGET:   cfg_d.target_sel = pwdata[0];
        REG_FAST_PRE: cfg_d.fast_pre   = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mgmt_phy   <= MGMT_PHY_RST;
      cfg_q.target_sel <= 1'b1;
      cfg_q.fast_pre   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Return register contents on reads
  always_comb begin
    case (reg_idx)
      REG_MGMT_PHY: prdata = PDATA_W'(cfg_q.mgmt_phy);
      REG_TARGET:   prdata = PDATA_W'(cfg_q.target_sel);
      REG_FAST_PRE: prdata = PDATA_W'(cfg_q.fast_pre);
      default:      prdata = '0;
    endcase
  end

  mcjb_front #(
    .PREAMBLE_BYTES (PREAMBLE_BYTES)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  mcjb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .pop_data_o  (pop_job)
  );

  mcjb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (job_valid),
    .job_i   (pop_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

FILE: rtl/mcjb_front.sv
// Front end: accepts items, keeps pin shadow and receive state, queues jobs.
module mcjb_front #(
  parameter int unsigned PREAMBLE_BYTES = mcjb_pkg::PREAMBLE_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcjb_pkg::cfg_t     cfg_i,
  mcjb_in_if.sink            in_i,
  input  logic               full_i,
  output logic               push_o,
  output mcjb_pkg::job_t     job_o
);
  import mcjb_pkg::*;

  logic [WORD_W-1:0] shadow_q, shadow_d;
  logic [FLEN_W-1:0] rx_cnt_q, rx_cnt_d;
  logic [WORD_W-1:0] hold_q, hold_d;
  logic [FLEN_W-1:0] flen_q, flen_d;

  logic              accept;
  logic [PRE_W-1:0]  pre_len;
  logic [FLEN_W-1:0] frame_len;
  logic [3:0]        tgt;

  // Accept whenever the queue has room
  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  assign pre_len   = cfg_i.fast_pre ? PRE_W'(1) : PRE_W'(PREAMBLE_BYTES);
  assign frame_len = FLEN_W'({pre_len, 1'b0}) + FLEN_W'(8);
  assign tgt       = {cfg_i.target_sel, 3'b000};

  // Classify the item and build its job
  always_comb begin
    logic              is_frame;
    logic              is_wr;
    logic [PHY_W-1:0]  phy;
    logic [DEV_W-1:0]  dev;
    logic [WORD_W-1:0] regw;
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] shadow_n;
    logic [WORD_W-1:0] hold_n;
    logic [FLEN_W-1:0] cnt_n;

    is_frame = 1'b0;
    is_wr    = 1'b1;
    phy      = cfg_i.mgmt_phy;
    dev      = JTAG_DEV;
    regw     = PIN_SHADOW_REG;
    data     = READ_FILL;
    shadow_n = shadow_q;
    hold_n   = {hold_q[BYTE_W-1:0], in_i.rx_byte};
    cnt_n    = rx_cnt_q + FLEN_W'(1);

    shadow_d = shadow_q;
    rx_cnt_d = rx_cnt_q;
    hold_d   = hold_q;
    flen_d   = flen_q;
    push_o   = 1'b0;
    job_o    = '0;
    job_o.pre_len = pre_len;

    if (accept) begin
      case (op_e'(in_i.op))
        OP_MDIO_WR: begin
          is_frame = 1'b1;
          phy      = in_i.phy_field;
          dev      = in_i.device_type;
          regw     = in_i.reg_addr;
          data     = in_i.write_data;
        end
        OP_MDIO_RD: begin
          is_frame = 1'b1;
          is_wr    = 1'b0;
          phy      = in_i.phy_field;
          dev      = in_i.device_type;
          regw     = in_i.reg_addr;
        end
        OP_JTAG_PINS: begin
          shadow_n[tgt + 4'd1] = in_i.tdi;
          shadow_n[tgt + 4'd3] = in_i.tck;
          shadow_n[tgt + 4'd2] = in_i.tms;
          shadow_d = shadow_n;
          is_frame = 1'b1;
          data     = shadow_n;
        end
        OP_JTAG_RST: begin
          shadow_n[tgt + 4'd4] = in_i.trst;
          shadow_d = shadow_n;
          is_frame = 1'b1;
          data     = shadow_n;
        end
        OP_TDO_SAMPLE: begin
          is_frame = 1'b1;
          is_wr    = 1'b0;
        end
        OP_RX_BYTE: begin
          // Count bytes of the pending frame, report on its last one
          if (flen_q != '0) begin
            hold_d   = hold_n;
            rx_cnt_d = cnt_n;
            if (cnt_n == flen_q) begin
              push_o           = 1'b1;
              job_o.is_done    = 1'b1;
              job_o.read_value = hold_n;
              job_o.tdo        = hold_n[tgt];
              rx_cnt_d         = '0;
              flen_d           = '0;
            end
          end
        end
        default: begin
        end
      endcase

      // Start a new frame, dropping any pending one
      if (is_frame) begin
        push_o           = 1'b1;
        job_o.addr_word  = {ADDR_CODE, phy, dev, TA_BITS, regw};
        job_o.value_word = {(is_wr ? WR_CODE : RD_CODE), phy, dev, TA_BITS, data};
        flen_d           = frame_len;
        rx_cnt_d         = '0;
        hold_d           = '0;
      end
    end
  end

  // Hold transaction state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_q <= '0;
      rx_cnt_q <= '0;
      hold_q   <= '0;
      flen_q   <= '0;
    end else begin
      shadow_q <= shadow_d;
      rx_cnt_q <= rx_cnt_d;
      hold_q   <= hold_d;
      flen_q   <= flen_d;
    end
  end

`ifndef SYNTH
  a_cnt_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flen_q != '0) |-> (rx_cnt_q < flen_q))
    else $error("receive count reached frame length without completing");

  a_idle_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flen_q == '0) |-> (rx_cnt_q == '0))
    else $error("receive count nonzero with no frame pending");

  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> accept)
    else $error("job pushed without an accepted item");
`endif

endmodule

FILE: rtl/mcjb_fifo.sv
// Short job queue between the front end and the serializer.
module mcjb_fifo #(
  parameter int unsigned DEPTH = mcjb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mcjb_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mcjb_pkg::job_t pop_data_o
);
  import mcjb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store queued jobs
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job taken from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count past its depth");
`endif

endmodule

FILE: rtl/mcjb_back.sv
// Serializer: turns queued jobs into frame bytes and read completions.
module mcjb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  mcjb_pkg::job_t job_i,
  output logic           pop_o,
  mcjb_out_if.source     out_o
);
  import mcjb_pkg::*;

  back_state_e      state_q, state_d;
  logic [PRE_W-1:0] cnt_q, cnt_d;
  job_t             cur_q;
  logic             cap_job;

  logic              ovalid_q, ovalid_d;
  logic              load;
  logic              r_tx_valid, r_tx_last, r_done, r_tdo;
  logic [BYTE_W-1:0] r_byte;
  logic [WORD_W-1:0] r_value;

  logic              tx_valid_q, tx_last_q, done_q, tdo_q;
  logic [BYTE_W-1:0] byte_q;
  logic [WORD_W-1:0] value_q;

  // Output register takes a new result when empty or drained
  assign load = !ovalid_q || out_o.ready;

  function automatic logic [BYTE_W-1:0] word_byte(
    input logic [FRAME_WORD_W-1:0] w,
    input logic [1:0]              sel
  );
    logic [BYTE_W-1:0] b;
    case (sel)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  // Step through preamble and word bytes
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cap_job    = 1'b0;
    pop_o      = 1'b0;
    ovalid_d   = ovalid_q && !out_o.ready;
    r_tx_valid = 1'b0;
    r_byte     = '0;
    r_tx_last  = 1'b0;
    r_done     = 1'b0;
    r_value    = '0;
    r_tdo      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          if (job_i.is_done) begin
            if (load) begin
              pop_o    = 1'b1;
              ovalid_d = 1'b1;
              r_done   = 1'b1;
              r_value  = job_i.read_value;
              r_tdo    = job_i.tdo;
            end
          end else begin
            pop_o   = 1'b1;
            cap_job = 1'b1;
            cnt_d   = '0;
            state_d = ST_PRE0;
          end
        end
      end
      ST_PRE0, ST_PRE1: begin
        if (load) begin
          ovalid_d   = 1'b1;
          r_tx_valid = 1'b1;
          r_byte     = PRE_BYTE;
          if (cnt_q + PRE_W'(1) == cur_q.pre_len) begin
            cnt_d   = '0;
            state_d = (state_q == ST_PRE0) ? ST_WORD0 : ST_WORD1;
          end else begin
            cnt_d = cnt_q + PRE_W'(1);
          end
        end
      end
      ST_WORD0, ST_WORD1: begin
        if (load) begin
          ovalid_d   = 1'b1;
          r_tx_valid = 1'b1;
          r_byte     = word_byte((state_q == ST_WORD0) ? cur_q.addr_word
                                                        : cur_q.value_word,
                                 cnt_q[1:0]);
          if (cnt_q[1:0] == 2'd3) begin
            cnt_d     = '0;
            r_tx_last = (state_q == ST_WORD1);
            state_d   = (state_q == ST_WORD0) ? ST_PRE1 : ST_IDLE;
          end else begin
            cnt_d = cnt_q + PRE_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Capture the job and the result payload
  always_ff @(posedge clk_i) begin
    if (cap_job) begin
      cur_q <= job_i;
    end
    if (ovalid_d && load) begin
      tx_valid_q <= r_tx_valid;
      byte_q     <= r_byte;
      tx_last_q  <= r_tx_last;
      done_q     <= r_done;
      value_q    <= r_value;
      tdo_q      <= r_tdo;
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.tx_valid   = tx_valid_q;
  assign out_o.tx_byte    = byte_q;
  assign out_o.tx_last    = tx_last_q;
  assign out_o.done_res   = done_q;
  assign out_o.read_value = value_q;
  assign out_o.tdo        = tdo_q;

`ifndef SYNTH
  a_pop_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE))
    else $error("job taken while a frame is still being sent");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && r_tx_last) |=> (state_q == ST_IDLE))
    else $error("last frame byte sent but serializer did not return to idle");

  a_pre_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PRE0) || (state_q == ST_PRE1)) |-> (cnt_q < cur_q.pre_len))
    else $error("preamble byte count past preamble length");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (tx_valid_q != done_q))
    else $error("result is neither a frame byte nor a completion");
`endif

endmodule

FILE: tb/sv/mcjb_frame_checker.sv
// Checker for the MDIO frame builder: predicts frame bytes and read completions, compares results.
module mcjb_frame_checker #(
  parameter int unsigned PREAMBLE_BYTES = mcjb_pkg::PREAMBLE_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mcjb_in_if                           in_i,
  mcjb_out_if                          out_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [mcjb_pkg::PADDR_W-1:0] paddr_i,
  input  logic [mcjb_pkg::PDATA_W-1:0] pwdata_i,
  input  logic                         pready_i,
  output int unsigned                  mism_cnt_o,
  output int unsigned                  res_pending_o
);
  import mcjb_pkg::*;

  // Frame constants of the pin shadow register and the value word
  localparam logic [4:0]  PIN_DEV   = 5'h1f;
  localparam logic [15:0] PIN_REG   = 16'h0010;
  localparam logic [15:0] WR_CMD    = 16'h1000;
  localparam logic [15:0] RD_CMD    = 16'h3000;
  localparam logic [15:0] RD_DATA   = 16'hffff;
  localparam logic [7:0]  PRE_FILL  = 8'hff;
  localparam logic [4:0]  PHY_RESET = 5'h1a;
  localparam int unsigned PRINT_CAP = 100;

  // Pin bit positions above the target offset
  localparam int unsigned TDI_OFS = 1;
  localparam int unsigned TMS_OFS = 2;
  localparam int unsigned TCK_OFS = 3;
  localparam int unsigned RST_OFS = 4;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        done_res;
    logic [15:0] read_value;
    logic        tdo;
  } line_res_t;

  line_res_t   line_q[$];
  logic [4:0]  cfg_phy;
  logic        cfg_tsel;
  logic        cfg_fast;
  logic [15:0] pins;
  logic [15:0] rx_sr;
  logic [4:0]  rx_cnt;
  logic [4:0]  flen;
  int unsigned mism = 0;
  int unsigned res_seen = 0;

  assign mism_cnt_o = mism;

  task automatic report_diff(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (mism < PRINT_CAP)
      $display("chk: result %0d %s: got 'h%0h, want 'h%0h", res_seen, what, got, want);
    mism++;
  endtask

  function automatic void push_byte(input logic [7:0] b, input logic last);
    line_res_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_byte  = b;
    r.tx_last  = last;
    line_q.push_back(r);
  endfunction

  // Build one frame: preamble, address word, preamble, value word; open a new reception
  function automatic void queue_frame(input logic wr, input logic [4:0] phy,
                                      input logic [4:0] dev, input logic [15:0] regw,
                                      input logic [15:0] data);
    logic [15:0]      cmd;
    logic [1:0][31:0] words;
    int unsigned      npre;
    cmd      = {4'h0, phy, dev, 2'b10};
    words[0] = {cmd, regw};
    words[1] = {cmd | (wr ? WR_CMD : RD_CMD), data};
    npre     = cfg_fast ? 1 : PREAMBLE_BYTES;
    for (int h = 0; h < 2; h++) begin
      repeat (npre) push_byte(PRE_FILL, 1'b0);
      for (int k = 3; k >= 0; k--)
        push_byte(words[h][8*k +: 8], (h == 1) && (k == 0));
    end
    flen   = 5'(2 * (npre + 4));
    rx_cnt = '0;
    rx_sr  = '0;
  endfunction

  // Advance the prediction by one accepted input item
  function automatic void take_item();
    int unsigned t;
    line_res_t   r;
    t = cfg_tsel ? 8 : 0;
    case (in_i.op)
      OP_MDIO_WR:
        queue_frame(1'b1, in_i.phy_field, in_i.device_type, in_i.reg_addr, in_i.write_data);
      OP_MDIO_RD:
        queue_frame(1'b0, in_i.phy_field, in_i.device_type, in_i.reg_addr, RD_DATA);
      OP_JTAG_PINS: begin
        pins[t+TDI_OFS] = in_i.tdi;
        pins[t+TCK_OFS] = in_i.tck;
        pins[t+TMS_OFS] = in_i.tms;
        queue_frame(1'b1, cfg_phy, PIN_DEV, PIN_REG, pins);
      end
      OP_JTAG_RST: begin
        pins[t+RST_OFS] = in_i.trst;
        queue_frame(1'b1, cfg_phy, PIN_DEV, PIN_REG, pins);
      end
      OP_TDO_SAMPLE:
        queue_frame(1'b0, cfg_phy, PIN_DEV, PIN_REG, RD_DATA);
      OP_RX_BYTE: begin
        // drop bytes while no frame waits for its answer
        if (flen != '0) begin
          rx_sr  = {rx_sr[7:0], in_i.rx_byte};
          rx_cnt = rx_cnt + 5'd1;
          if (rx_cnt == flen) begin
            r            = '0;
            r.done_res   = 1'b1;
            r.read_value = rx_sr;
            r.tdo        = rx_sr[t];
            line_q.push_back(r);
            rx_cnt = '0;
            flen   = '0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    line_res_t want;
    if (!rst_ni) begin
      line_q.delete();
      cfg_phy  = PHY_RESET;
      cfg_tsel = 1'b1;
      cfg_fast = 1'b0;
      pins     = '0;
      rx_sr    = '0;
      rx_cnt   = '0;
      flen     = '0;
      res_pending_o <= 0;
    end else begin
      // compare results first: none can stem from an item taken at this edge
      if (out_i.valid && out_i.ready) begin
        if (line_q.size() == 0) begin
          report_diff("arrived with nothing outstanding, tx_byte", 32'(out_i.tx_byte),
                      32'd0);
        end else begin
          want = line_q.pop_front();
          if (out_i.tx_valid !== want.tx_valid)
            report_diff("tx_valid", 32'(out_i.tx_valid), 32'(want.tx_valid));
          if (out_i.tx_byte !== want.tx_byte)
            report_diff("tx_byte", 32'(out_i.tx_byte), 32'(want.tx_byte));
          if (out_i.tx_last !== want.tx_last)
            report_diff("tx_last", 32'(out_i.tx_last), 32'(want.tx_last));
          if (out_i.done_res !== want.done_res)
            report_diff("done_res", 32'(out_i.done_res), 32'(want.done_res));
          if (out_i.read_value !== want.read_value)
            report_diff("read_value", 32'(out_i.read_value), 32'(want.read_value));
          if (out_i.tdo !== want.tdo)
            report_diff("tdo", 32'(out_i.tdo), 32'(want.tdo));
        end
        res_seen++;
      end
      if (in_i.valid && in_i.ready)
        take_item();
      // track register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PADDR_W-1:2])
          REG_MGMT_PHY: cfg_phy  = pwdata_i[4:0];
          REG_TARGET:   cfg_tsel = pwdata_i[0];
          REG_FAST_PRE: cfg_fast = pwdata_i[0];
          default: ;
        endcase
      end
      res_pending_o <= line_q.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
// Testbench top: drives items and register writes into the MDIO frame builder and paces results.
module tb;
  import mcjb_pkg::*;

  localparam int unsigned FRAME_PRE   = PREAMBLE_BYTES_DEF;
  localparam int unsigned HOLD_CYC    = 300;
  localparam int unsigned SETTLE_CYC  = 24;
  localparam int unsigned TAIL_CYC    = 64;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 36;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PHY_W-1:0]  phy_field;
    logic [DEV_W-1:0]  device_type;
    logic [WORD_W-1:0] reg_addr;
    logic [WORD_W-1:0] write_data;
    logic              tck;
    logic              tms;
    logic              tdi;
    logic              trst;
    logic [BYTE_W-1:0] rx_byte;
  } mdio_req_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int unsigned        mism_cnt;
  int unsigned        res_pending;
  logic               hold_tgl;
  bit                 burst;
  logic               fast_now;
  int unsigned        items_in;
  int unsigned        stall_cycles = 0;

  mcjb_in_if  in_ch ();
  mcjb_out_if out_ch ();

  mdio_c45_jtag_bridge_framer #(
    .PREAMBLE_BYTES(FRAME_PRE)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  mcjb_frame_checker #(
    .PREAMBLE_BYTES(FRAME_PRE)
  ) u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .mism_cnt_o   (mism_cnt),
    .res_pending_o(res_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Pace the result side: short runs, long stalls now and then, one long hold on request
  initial begin : result_pacing
    logic        hold_ack;
    logic        lvl;
    int unsigned len;
    int unsigned r;
    out_ch.ready <= 1'b0;
    hold_ack = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_tgl != hold_ack) begin
        hold_ack = hold_tgl;
        lvl      = 1'b0;
        len      = HOLD_CYC;
      end else if (r < 10) begin
        lvl = 1'b1;
        len = $urandom_range(40, 100);
      end else if (r < 55) begin
        lvl = 1'b1;
        len = $urandom_range(1, 8);
      end else if (r < 92) begin
        lvl = 1'b0;
        len = $urandom_range(1, 3);
      end else begin
        lvl = 1'b0;
        len = $urandom_range(15, 60);
      end
      out_ch.ready <= lvl;
      repeat (len) @(posedge clk);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned frame_len();
    return 2 * ((fast_now ? 1 : FRAME_PRE) + 4);
  endfunction

  function automatic mdio_req_t any_req(input logic [OP_W-1:0] op);
    mdio_req_t q;
    q.op          = op;
    q.phy_field   = PHY_W'($urandom);
    q.device_type = DEV_W'($urandom);
    q.reg_addr    = WORD_W'($urandom);
    q.write_data  = WORD_W'($urandom);
    q.tck         = 1'($urandom);
    q.tms         = 1'($urandom);
    q.tdi         = 1'($urandom);
    q.trst        = 1'($urandom);
    q.rx_byte     = BYTE_W'($urandom);
    return q;
  endfunction

  // Offer one item after a random gap; return at the edge that takes it, valid left high
  task automatic offer(input mdio_req_t q);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= q.op;
    in_ch.phy_field   <= q.phy_field;
    in_ch.device_type <= q.device_type;
    in_ch.reg_addr    <= q.reg_addr;
    in_ch.write_data  <= q.write_data;
    in_ch.tck         <= q.tck;
    in_ch.tms         <= q.tms;
    in_ch.tdi         <= q.tdi;
    in_ch.trst        <= q.trst;
    in_ch.rx_byte     <= q.rx_byte;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic frame_op(input logic [OP_W-1:0] op);
    offer(any_req(op));
    items_in++;
  endtask

  task automatic feed_bytes(input int unsigned n);
    repeat (n) begin
      offer(any_req(OP_RX_BYTE));
      items_in++;
    end
  endtask

  // Hold off the input until every predicted result is out, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (res_pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write all three registers; upper bits are junk the block must ignore
  task automatic set_config(input logic [4:0] phy, input logic tsel, input logic fast);
    reg_write(REG_MGMT_PHY, {27'($urandom), phy});
    reg_write(REG_TARGET, {31'($urandom), tsel});
    reg_write(REG_FAST_PRE, {31'($urandom), fast});
    fast_now = fast;
  endtask

  function automatic logic [OP_W-1:0] any_frame_op();
    return OP_W'($urandom_range(OP_MDIO_WR, OP_TDO_SAMPLE));
  endfunction

  // One random transaction: mostly a frame with its full reception, else a partial one, two frames or noise
  task automatic random_transaction();
    int unsigned r;
    int unsigned n;
    burst = ($urandom_range(0, 4) == 0);
    r     = $urandom_range(0, 99);
    if (r < 70) begin
      frame_op(any_frame_op());
      n = frame_len();
      if ($urandom_range(0, 3) == 0)
        n = $urandom_range(0, n - 1);
      feed_bytes(n);
      if (n == frame_len() && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) offer(any_req(OP_RX_BYTE));
    end else if (r < 85) begin
      repeat (2) frame_op(any_frame_op());
    end else begin
      offer(any_req(OP_W'($urandom_range(0, 7))));
    end
    burst = 1'b0;
    if ($urandom_range(0, 11) == 0)
      drain();
  endtask

  initial begin : stimulus
    mdio_req_t   q;
    int unsigned stop_at;
    rst_n    = 1'b0;
    hold_tgl = 1'b0;
    burst    = 1'b0;
    fast_now = 1'b0;
    items_in = 0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= '0;
    in_ch.phy_field   <= '0;
    in_ch.device_type <= '0;
    in_ch.reg_addr    <= '0;
    in_ch.write_data  <= '0;
    in_ch.tck         <= 1'b0;
    in_ch.tms         <= 1'b0;
    in_ch.tdi         <= 1'b0;
    in_ch.trst        <= 1'b0;
    in_ch.rx_byte     <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte with nothing pending right after reset
    offer(any_req(OP_RX_BYTE));
    // raw frames with all-ones and all-zeros operands, then a raw read
    q = any_req(OP_MDIO_WR);
    q.phy_field   = '1;
    q.device_type = '1;
    q.reg_addr    = '1;
    q.write_data  = '1;
    offer(q);
    q = any_req(OP_MDIO_WR);
    q.phy_field   = '0;
    q.device_type = '0;
    q.reg_addr    = '0;
    q.write_data  = '0;
    offer(q);
    q = any_req(OP_MDIO_RD);
    q.phy_field   = 5'h15;
    q.device_type = 5'h0a;
    q.reg_addr    = 16'ha5a5;
    offer(q);
    // pin shadow updates, set and clear
    q = any_req(OP_JTAG_PINS);
    q.tck = 1'b1;
    q.tms = 1'b1;
    q.tdi = 1'b1;
    offer(q);
    q = any_req(OP_JTAG_RST);
    q.trst = 1'b1;
    offer(q);
    q = any_req(OP_JTAG_PINS);
    q.tck = 1'b0;
    q.tms = 1'b0;
    q.tdi = 1'b1;
    offer(q);
    q = any_req(OP_JTAG_RST);
    q.trst = 1'b0;
    offer(q);
    // unused op codes
    offer(any_req(3'd6));
    offer(any_req(3'd7));
    offer(any_req(OP_TDO_SAMPLE));
    // switch target while the sample frame awaits its answer, then answer it
    drain();
    reg_write(REG_TARGET, '0);
    q = any_req(OP_RX_BYTE);
    q.rx_byte = 8'h00;
    offer(q);
    q.rx_byte = 8'hff;
    offer(q);
    feed_bytes(frame_len() - 4);
    q.rx_byte = 8'h80;
    offer(q);
    q.rx_byte = 8'h01;
    offer(q);

    // random phases, each under its own register setting
    items_in = 0;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0:       set_config(5'd31, 1'b0, 1'b1);
        1:       set_config(5'd0, 1'b1, 1'b0);
        2:       set_config(5'd31, 1'b1, 1'b1);
        default: set_config(5'($urandom), 1'($urandom), 1'($urandom));
      endcase
      // stall the result side for a long stretch while frames keep coming
      if (ph == 1 || ph == 3) begin
        hold_tgl <= ~hold_tgl;
        burst = 1'b1;
        repeat (8) frame_op(any_frame_op());
        burst = 1'b0;
      end
      stop_at = items_in + PHASE_ITEMS;
      while (items_in < stop_at) random_transaction();
    end

    drain();
    repeat (TAIL_CYC) @(posedge clk);
    if (mism_cnt == 0 && res_pending == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

FILE: mdio_c45_jtag_bridge_framer.f
rtl/mcjb_pkg.sv
rtl/mcjb_in_if.sv
rtl/mcjb_out_if.sv
rtl/mcjb_front.sv
rtl/mcjb_fifo.sv
rtl/mcjb_back.sv
rtl/mdio_c45_jtag_bridge_framer.sv
tb/sv/mcjb_frame_checker.sv
tb/sv/tb.sv
